// ===== rtl/spmf_pkg.sv =====
// shared constants and controller/datapath interface types for the priority queue
package spmf_pkg;

    localparam int LEVELS_DEF      = 4;
    localparam int LEVEL_DEPTH_DEF = 16;

    localparam int CFG_W           = 3;
    localparam logic [CFG_W-1:0] LEVELS_IN_USE_RST = 3'd4;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_PRIO = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic latch;     // capture the accepted word
        logic exec;      // evaluate the held word and update the queues
        logic deq_load;  // move the read byte into the output register
    } spmf_cmd_t;

    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
        logic deq_hit;   // held word is a dequeue that finds a byte
    } spmf_stat_t;

endpackage

// ===== rtl/strict_priority_multi_fifo.sv =====
// top level of the strict-priority multi-level byte queue
//
// channel  dir  handshake            payload
// s_       in   s_tvalid/s_tready    s_tdata: data_in, priority_req; s_tuser: operation
// m_       out  m_tvalid/m_tready    m_tdata: data_out; m_tuser: status
// cfg_     in   cfg_valid/cfg_ready  cfg_data: levels_in_use
//
// enqueue or empty dequeue: accept, then execute; a dequeue that finds a byte adds
// a read step after execute, set by the registered read of the byte store
// one word in flight; the next word is taken while a result waits in the output register
// a stalled m_ side holds the execute step once the output register is occupied
// reset clears all levels to empty and levels_in_use to 4; stored bytes need no clearing
module strict_priority_multi_fifo
    import spmf_pkg::*;
#(
    parameter int LEVELS      = LEVELS_DEF,
    parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,   // data_in [7:0], priority_req [11:8], zero fill
    input  logic [0:0]       s_tuser,   // operation [0]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // data_out [7:0]
    output logic [1:0]       m_tuser,   // status [1:0]
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    spmf_cmd_t  cmd;
    spmf_stat_t stat;

    assign cfg_ready = 1'b1;

    spmf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    spmf_dp #(
        .LEVELS      (LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .op_in      (s_tuser[0]),
        .data_in    (s_tdata[7:0]),
        .prio_in    (s_tdata[11:8]),
        .cmd        (cmd),
        .stat       (stat),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .status_out (m_tuser),
        .data_out   (m_tdata)
    );

endmodule

// ===== rtl/spmf_ctrl.sv =====
// controller state machine: accept, execute and dequeue read sequencing
module spmf_ctrl
    import spmf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  spmf_stat_t stat,
    output spmf_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DEQ  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.latch    = 1'b0;
        cmd.exec     = 1'b0;
        cmd.deq_load = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                // wait for room in the output register before touching state
                if (stat.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = stat.deq_hit ? S_DEQ : S_IDLE;
                end
            end
            S_DEQ: begin
                cmd.deq_load = 1'b1;
                state_next   = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/spmf_dp.sv =====
// datapath: per-level ring pointers, byte store, level encoder and output register
module spmf_dp
    import spmf_pkg::*;
#(
    parameter int LEVELS      = LEVELS_DEF,
    parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             op_in,
    input  logic [7:0]       data_in,
    input  logic [3:0]       prio_in,
    input  spmf_cmd_t        cmd,
    output spmf_stat_t       stat,
    input  logic             m_tready,
    output logic             m_tvalid,
    output logic [1:0]       status_out,
    output logic [7:0]       data_out
);

    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PTR_W  = $clog2(LEVEL_DEPTH);
    localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int MEM_D  = LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W = $clog2(MEM_D);
    localparam logic [4:0]       LEVELS_W5 = 5'(LEVELS);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(LEVEL_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(LEVEL_DEPTH);

    logic [CFG_W-1:0] levels_reg;
    logic             op_reg;
    logic [7:0]       data_reg;
    logic [3:0]       prio_reg;
    logic [PTR_W-1:0] head_reg  [LEVELS];
    logic [PTR_W-1:0] tail_reg  [LEVELS];
    logic [CNT_W-1:0] count_reg [LEVELS];
    logic [7:0]       mem       [MEM_D];
    logic [7:0]       rd_data_reg;
    logic             out_valid_reg;
    logic [1:0]       out_status_reg;
    logic [7:0]       out_data_reg;

    logic [4:0]        limit;
    logic              bad_prio;
    logic              deq_found;
    logic [LVL_W-1:0]  deq_idx;
    logic [LVL_W-1:0]  sel_idx;
    logic [CNT_W-1:0]  sel_count;
    logic [PTR_W-1:0]  sel_head;
    logic [PTR_W-1:0]  sel_tail;
    logic              lvl_full;
    logic              enq_ok;
    logic              deq_hit;
    logic [ADDR_W-1:0] base_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [1:0]        exec_status;
    logic              out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg <= LEVELS_IN_USE_RST;
        end else if (cfg_we) begin
            levels_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg   <= op_in;
            data_reg <= data_in;
            prio_reg <= prio_in;
        end
    end

    // register values above the level count act as the level count
    always_comb begin
        limit = ({2'b00, levels_reg} > LEVELS_W5) ? LEVELS_W5 : {2'b00, levels_reg};
        bad_prio = ({1'b0, prio_reg} >= limit);
    end

    // most urgent nonempty level, scanned from the least urgent down
    always_comb begin
        deq_found = 1'b0;
        deq_idx   = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (count_reg[i] != '0) begin
                deq_found = 1'b1;
                deq_idx   = LVL_W'(i);
            end
        end
    end

    always_comb begin
        sel_idx     = (op_reg == OP_DEQ) ? deq_idx : prio_reg[LVL_W-1:0];
        sel_count   = count_reg[sel_idx];
        sel_head    = head_reg[sel_idx];
        sel_tail    = tail_reg[sel_idx];
        lvl_full    = (sel_count == CNT_FULL);
        enq_ok      = (op_reg == OP_ENQ) && !bad_prio && !lvl_full;
        deq_hit     = (op_reg == OP_DEQ) && deq_found;
        base_addr   = ADDR_W'(sel_idx * LEVEL_DEPTH);
        wr_addr     = base_addr + ADDR_W'(sel_tail);
        rd_addr     = base_addr + ADDR_W'(sel_head);
        if (op_reg == OP_DEQ) begin
            exec_status = ST_EMPTY;
        end else if (bad_prio) begin
            exec_status = ST_BAD_PRIO;
        end else if (lvl_full) begin
            exec_status = ST_FULL;
        end else begin
            exec_status = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else if (cmd.exec) begin
            if (enq_ok) begin
                tail_reg[sel_idx]  <= (sel_tail == PTR_LAST) ? '0 : sel_tail + 1'b1;
                count_reg[sel_idx] <= sel_count + 1'b1;
            end else if (deq_hit) begin
                head_reg[sel_idx]  <= (sel_head == PTR_LAST) ? '0 : sel_head + 1'b1;
                count_reg[sel_idx] <= sel_count - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && enq_ok) begin
            mem[wr_addr] <= data_reg;
        end
        if (cmd.exec && deq_hit) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if ((cmd.exec && !deq_hit) || cmd.deq_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && !deq_hit) begin
            out_status_reg <= exec_status;
            out_data_reg   <= 8'h00;
        end else if (cmd.deq_load) begin
            out_status_reg <= ST_OK;
            out_data_reg   <= rd_data_reg;
        end
    end

    assign stat.out_free = out_free;
    assign stat.deq_hit  = deq_hit;
    assign m_tvalid      = out_valid_reg;
    assign status_out    = out_status_reg;
    assign data_out      = out_data_reg;

endmodule

// ===== rtl/spmf_checker.sv =====
// port-level checks for the priority queue and their bind to the top level
module spmf_checker
    import spmf_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [1:0]  m_tuser
);

    // a result held under backpressure keeps its word
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // only a successful dequeue carries a byte
    a_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) |-> m_tdata == 8'h00)
        else $error("nonzero data on a failed result");

    // one word at a time: the cycle after an accept takes nothing
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a word is in flight");

    // a new result is produced only while the input side is busy
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a word in flight");

endmodule

bind strict_priority_multi_fifo spmf_checker u_spmf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
